// ----- hdl/bpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared sizes, operation codes and the controller/datapath interface types
// of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAP_PAGES = 65536;
    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = MAP_PAGES / WORD_BITS;
    localparam int WA_W      = $clog2(NUM_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int PW        = $clog2(MAP_PAGES) + 1;   // page position 0..MAP_PAGES
    localparam int CNT_W     = 17;
    localparam int PAGE_W    = 16;
    localparam int MODE_W    = 2;
    localparam int EXT_W     = ((PW > CNT_W) ? PW : CNT_W) + 1;

    localparam logic [CNT_W-1:0] CNT_MAX       = '1;
    localparam logic [CNT_W-1:0] LOW_RES_RESET = CNT_W'(256);

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_ADD     = 2'd2,
        MODE_RESERVE = 2'd3
    } t_mode;

    // controller -> datapath
    typedef struct packed {
        logic clr;       // write one all-used word of the clearing pass
        logic capture;   // take the input transaction
        logic prep;      // set up range bounds and first word
        logic rd;        // read bitmap word
        logic modify;    // write back the modified word
        logic scan;      // evaluate word for a free run
        logic fin;       // update counters
        logic out_load;  // load result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic empty;
        logic is_alloc;
        logic last;
        logic hit;
    } t_stat;

endpackage

// ----- hdl/bpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: clearing pass, range walk and first-fit scan.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_free,
    input  bpa_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output bpa_pkg::t_cmd  o_cmd
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PREP, S_RD, S_MOD, S_SCAN_RD, S_SCAN_EV, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR:   if (i_stat.clr_last) r_state <= S_IDLE;
                S_IDLE:    if (i_in_valid) r_state <= S_PREP;
                S_PREP: begin
                    priority if (i_stat.empty)    r_state <= S_FIN;
                    else if (i_stat.is_alloc)     r_state <= S_SCAN_RD;
                    else                          r_state <= S_RD;
                end
                S_RD:      r_state <= S_MOD;
                S_MOD:     r_state <= i_stat.last ? S_FIN : S_RD;
                S_SCAN_RD: r_state <= S_SCAN_EV;
                S_SCAN_EV: begin
                    priority if (i_stat.hit) r_state <= S_RD;
                    else if (i_stat.last)    r_state <= S_FIN;
                    else                     r_state <= S_SCAN_RD;
                end
                S_FIN:     r_state <= S_OUT;
                S_OUT:     if (i_out_free) r_state <= S_IDLE;
                default:   r_state <= S_CLEAR;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_in_ready     = (r_state == S_IDLE);
        o_cmd.clr      = (r_state == S_CLEAR);
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.rd       = (r_state == S_RD) || (r_state == S_SCAN_RD);
        o_cmd.modify   = (r_state == S_MOD);
        o_cmd.scan     = (r_state == S_SCAN_EV);
        o_cmd.fin      = (r_state == S_FIN);
        o_cmd.out_load = (r_state == S_OUT) && i_out_free;
    end

endmodule

// ----- hdl/bpa_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_dpath
// Bitmap memory, range mask generation, run search and page counters.
// ----------------------------------------------------------------------------
module bpa_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bpa_pkg::t_cmd                i_cmd,
    output bpa_pkg::t_stat               o_stat,
    input  logic [bpa_pkg::MODE_W-1:0]   i_mode,
    input  logic [bpa_pkg::PAGE_W-1:0]   i_first,
    input  logic [bpa_pkg::CNT_W-1:0]    i_count,
    input  logic [bpa_pkg::CNT_W-1:0]    i_low_res,
    output logic                         o_ok,
    output logic [bpa_pkg::PAGE_W-1:0]   o_alloc_page,
    output logic [bpa_pkg::CNT_W-1:0]    o_free_pages,
    output logic [bpa_pkg::CNT_W-1:0]    o_total
);
    import bpa_pkg::*;

    localparam logic [WORD_BITS-1:0] ONES = '1;

    function automatic logic [CNT_W-1:0] sat_add(input logic [EXT_W-1:0] a,
                                                  input logic [EXT_W-1:0] b);
        logic [EXT_W-1:0] s;
        s = a + b;
        return (s > EXT_W'(CNT_MAX)) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    t_mode              r_mode;
    logic [PAGE_W-1:0]  r_first;
    logic [CNT_W-1:0]   r_count;
    logic [PW-1:0]      r_lo, r_hi;
    logic [WA_W-1:0]    r_waddr;
    logic [EXT_W-1:0]   r_carry;
    logic [PW-1:0]      r_fresh;
    logic [CNT_W-1:0]   r_total, r_used;
    logic [PW-1:0]      r_limit;
    logic               r_ok;
    logic [PAGE_W-1:0]  r_base;

    logic [EXT_W-1:0]     sum_ext, end_ext, len_ext, lim_ext;
    logic [PW-1:0]        lo_n, hi_n, hi_m1;
    logic [WA_W-1:0]      w0, w1;
    logic [WORD_BITS-1:0] mask, wdata_mod, eff_used;
    logic [BIT_W:0]       fresh_word;
    logic                 is_alloc, empty;

    logic                 lv_has [0:BIT_W][0:WORD_BITS-1];
    logic [BIT_W-1:0]     lv_idx [0:BIT_W][0:WORD_BITS-1];
    logic [WORD_BITS-1:0] hit_vec;
    logic [BIT_W-1:0]     hit_pos;
    logic [EXT_W-1:0]     run_b, base_ext, carry_n;

    // range bounds of the captured operation
    always_comb begin
        is_alloc = (r_mode == MODE_ALLOC);
        sum_ext  = EXT_W'(r_first) + EXT_W'(r_count);
        end_ext  = (sum_ext > EXT_W'(MAP_PAGES)) ? EXT_W'(MAP_PAGES) : sum_ext;
        len_ext  = (end_ext > EXT_W'(r_first)) ? end_ext - EXT_W'(r_first) : '0;
        lim_ext  = (EXT_W'(r_limit) > EXT_W'(MAP_PAGES)) ? EXT_W'(MAP_PAGES)
                                                         : EXT_W'(r_limit);
        if (is_alloc) begin
            empty = (r_count == '0) || (EXT_W'(i_low_res) >= lim_ext);
            lo_n  = PW'(i_low_res);
            hi_n  = PW'(lim_ext);
        end else begin
            empty = (len_ext == '0);
            lo_n  = PW'(r_first);
            hi_n  = PW'(end_ext);
        end
    end

    // mask of in-range bits of the current word
    always_comb begin
        hi_m1 = r_hi - 1'b1;
        w0    = r_lo[BIT_W +: WA_W];
        w1    = hi_m1[BIT_W +: WA_W];
        mask  = ((r_waddr == w0) ? (ONES << r_lo[BIT_W-1:0]) : ONES)
              & ((r_waddr == w1) ? (ONES >> (~hi_m1[BIT_W-1:0])) : ONES);
        wdata_mod  = (r_mode == MODE_FREE || r_mode == MODE_ADD) ? (r_rdata & ~mask)
                                                                  : (r_rdata | mask);
        fresh_word = (BIT_W+1)'($countones(mask & ~r_rdata));
        eff_used   = r_rdata | ~mask;
    end

    // run search: prefix scan for the last used bit at or below each position
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            lv_has[0][b] = eff_used[b];
            lv_idx[0][b] = BIT_W'(b);
        end
        for (int l = 0; l < BIT_W; l++) begin
            for (int b = 0; b < WORD_BITS; b++) begin
                if (b >= (1 << l) && !lv_has[l][b]) begin
                    lv_has[l+1][b] = lv_has[l][b - (1 << l)];
                    lv_idx[l+1][b] = lv_idx[l][b - (1 << l)];
                end else begin
                    lv_has[l+1][b] = lv_has[l][b];
                    lv_idx[l+1][b] = lv_idx[l][b];
                end
            end
        end
        run_b = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            run_b = lv_has[BIT_W][b] ? EXT_W'(BIT_W'(b) - lv_idx[BIT_W][b])
                                     : r_carry + EXT_W'(b) + EXT_W'(1);
            hit_vec[b] = (run_b >= EXT_W'(r_count));
        end
        hit_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (hit_vec[b]) hit_pos = BIT_W'(b);
        end
        base_ext = EXT_W'({r_waddr, hit_pos}) + EXT_W'(1) - EXT_W'(r_count);
        carry_n  = lv_has[BIT_W][WORD_BITS-1]
                 ? EXT_W'(BIT_W'(WORD_BITS - 1) - lv_idx[BIT_W][WORD_BITS-1])
                 : r_carry + EXT_W'(WORD_BITS);
    end

    assign o_stat.clr_last = (r_waddr == WA_W'(NUM_WORDS - 1));
    assign o_stat.empty    = empty;
    assign o_stat.is_alloc = is_alloc;
    assign o_stat.last     = (r_waddr == w1);
    assign o_stat.hit      = |hit_vec;

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_waddr] <= ONES;
        end else if (i_cmd.modify) begin
            r_mem[r_waddr] <= wdata_mod;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_waddr];
        end
    end

    // operation payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= t_mode'(i_mode);
            r_first <= i_first;
            r_count <= i_count;
        end
        if (i_cmd.prep) begin
            r_lo    <= lo_n;
            r_hi    <= hi_n;
            r_carry <= '0;
            r_fresh <= '0;
            r_ok    <= !is_alloc;
            r_base  <= '0;
        end
        if (i_cmd.modify) begin
            r_fresh <= r_fresh + PW'(fresh_word);
        end
        if (i_cmd.scan) begin
            r_carry <= carry_n;
            if (|hit_vec) begin
                r_lo   <= PW'(base_ext);
                r_hi   <= PW'(base_ext + EXT_W'(r_count));
                r_ok   <= 1'b1;
                r_base <= PAGE_W'(base_ext);
            end
        end
    end

    // word pointer and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waddr <= '0;
            r_total <= '0;
            r_used  <= '0;
            r_limit <= '0;
        end else begin
            if (i_cmd.clr || i_cmd.modify) begin
                r_waddr <= r_waddr + 1'b1;
            end
            if (i_cmd.prep) begin
                r_waddr <= lo_n[BIT_W +: WA_W];
            end
            if (i_cmd.scan) begin
                if (|hit_vec) r_waddr <= base_ext[BIT_W +: WA_W];
                else          r_waddr <= r_waddr + 1'b1;
            end
            if (i_cmd.fin) begin
                unique case (r_mode)
                    MODE_ALLOC: begin
                        if (r_ok) r_used <= sat_add(EXT_W'(r_used), EXT_W'(r_count));
                    end
                    MODE_FREE: begin
                        r_used <= (r_used > r_count) ? r_used - r_count : '0;
                    end
                    MODE_ADD: begin
                        r_total <= sat_add(EXT_W'(r_total), len_ext);
                        if (end_ext > EXT_W'(r_limit)) r_limit <= PW'(end_ext);
                    end
                    MODE_RESERVE: begin
                        r_used <= sat_add(EXT_W'(r_used), EXT_W'(r_fresh));
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_ok         = r_ok;
    assign o_alloc_page = r_base;
    assign o_free_pages = (r_total > r_used) ? r_total - r_used : '0;
    assign o_total      = r_total;

endmodule

// ----- hdl/bitmap_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a one-bit-per-page used/free bitmap.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NUM_WORDS words (1024 for
// 65536 pages in 64-bit words) that marks every page used; no transaction is
// taken on the input stream until it ends, while configuration writes are
// taken at once. Each input transaction is then handled on its own and gives
// one result transaction. The bitmap lives in a single-port memory with a
// registered read, so every word touched takes a read step and then a
// modify-write or evaluate step: free, add-usable and reserve walk the words
// spanned by the clipped range; alloc scans words from low_reserved_pages up
// to the first fitting run and then walks the words covered by the run. The
// scan examines one whole word per evaluation, so a run that crosses word
// edges is found without extra cost. A finished result waits in the output
// register while the next transaction is accepted and worked on.
// ----------------------------------------------------------------------------
module bitmap_page_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: low_reserved_pages
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [15:0] first_page, [32:16] page_count
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [15:0] alloc_page, [32:16] free_pages,
                                        // [49:33] total_usable
    output logic [0:0]  m_axis_tuser    // [0] ok
);
    import bpa_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [CNT_W-1:0]  r_low_res;
    logic              r_out_valid;
    logic [55:0]       r_out_data;
    logic              r_out_ok;
    logic              out_free;
    logic              res_ok;
    logic [PAGE_W-1:0] res_page;
    logic [CNT_W-1:0]  res_free, res_total;

    // Config register, always ready: user writes it only while idle, unchecked.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_res <= LOW_RES_RESET;
        end else if (i_cfg_valid) begin
            r_low_res <= i_cfg_data;
        end
    end

    // Output register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || m_axis_tready;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    bpa_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (s_axis_tuser),
        .i_first      (s_axis_tdata[15:0]),
        .i_count      (s_axis_tdata[32:16]),
        .i_low_res    (r_low_res),
        .o_ok         (res_ok),
        .o_alloc_page (res_page),
        .o_free_pages (res_free),
        .o_total      (res_total)
    );

    // Hold the result until the downstream side takes the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out_data <= {6'd0, res_total, res_free, res_page};
            r_out_ok   <= res_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ok;

endmodule

// ----- dv/bpa_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_result_checker
// Watches the configuration, request and result channels of the page
// allocator, keeps a bit-level model of its bitmap and counters, and compares
// every result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module bpa_result_checker
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [16:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [39:0] i_req_data,
    input  logic [1:0]  i_req_user,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [55:0] i_rsp_data,
    input  logic [0:0]  i_rsp_user,
    input  logic        i_end_check,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic              ok;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  free_cnt;
        logic [CNT_W-1:0]  total_cnt;
    } t_alloc_rsp;

    logic [MAP_PAGES-1:0] page_map;
    int unsigned          total_q, used_q, limit_q, low_res_q;
    t_alloc_rsp           rsp_queue[$];

    assign o_pending = rsp_queue.size();

    function automatic int unsigned sat_cnt(int unsigned v);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    task automatic apply_request(t_mode op, int unsigned first, int unsigned cnt);
        int unsigned stop, run, lim, base, fresh;
        t_alloc_rsp  r;
        r     = '0;
        r.ok  = 1'b1;
        stop  = (first + cnt > MAP_PAGES) ? MAP_PAGES : first + cnt;
        case (op)
            MODE_ALLOC: begin
                r.ok = 1'b0;
                if (cnt != 0) begin
                    lim = (limit_q > MAP_PAGES) ? MAP_PAGES : limit_q;
                    run = 0;
                    for (int unsigned p = low_res_q; p < lim; p++) begin
                        run = page_map[p] ? 0 : run + 1;
                        if (run == cnt) begin
                            base = p + 1 - cnt;
                            for (int unsigned q = base; q <= p; q++) page_map[q] = 1'b1;
                            used_q = sat_cnt(used_q + cnt);
                            r.page = base[PAGE_W-1:0];
                            r.ok   = 1'b1;
                            break;
                        end
                    end
                end
            end
            MODE_FREE: begin
                for (int unsigned p = first; p < stop; p++) page_map[p] = 1'b0;
                used_q = (used_q > cnt) ? used_q - cnt : 0;
            end
            MODE_ADD: begin
                for (int unsigned p = first; p < stop; p++) page_map[p] = 1'b0;
                total_q = sat_cnt(total_q + ((stop > first) ? stop - first : 0));
                if (stop > limit_q) limit_q = stop;
            end
            default: begin
                fresh = 0;
                for (int unsigned p = first; p < stop; p++) begin
                    if (!page_map[p]) begin
                        page_map[p] = 1'b1;
                        fresh++;
                    end
                end
                used_q = sat_cnt(used_q + fresh);
            end
        endcase
        r.free_cnt  = CNT_W'((total_q > used_q) ? total_q - used_q : 0);
        r.total_cnt = total_q[CNT_W-1:0];
        rsp_queue.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_alloc_rsp exp_r;
        int         errs;
        errs = 0;
        if (!i_rst_n) begin
            page_map  = '1;
            total_q   = 0;
            used_q    = 0;
            limit_q   = 0;
            low_res_q = 32'(LOW_RES_RESET);
            o_errors  <= 0;
            rsp_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) low_res_q = 32'(i_cfg_data);
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_queue.size() == 0) begin
                    $error("unexpected result transaction");
                    errs++;
                end else begin
                    exp_r = rsp_queue.pop_front();
                    if (i_rsp_user[0] !== exp_r.ok) begin
                        $error("ok: expected %0d actual %0d", exp_r.ok, i_rsp_user[0]);
                        errs++;
                    end
                    if (i_rsp_data[15:0] !== exp_r.page) begin
                        $error("alloc_page: expected %0d actual %0d", exp_r.page,
                               i_rsp_data[15:0]);
                        errs++;
                    end
                    if (i_rsp_data[32:16] !== exp_r.free_cnt) begin
                        $error("free_pages: expected %0d actual %0d", exp_r.free_cnt,
                               i_rsp_data[32:16]);
                        errs++;
                    end
                    if (i_rsp_data[49:33] !== exp_r.total_cnt) begin
                        $error("total_usable: expected %0d actual %0d", exp_r.total_cnt,
                               i_rsp_data[49:33]);
                        errs++;
                    end
                end
            end
            // request after the result check: the block answers one at a time
            if (i_req_valid && i_req_ready)
                apply_request(t_mode'(i_req_user), 32'(i_req_data[15:0]),
                              32'(i_req_data[32:16]));
            if (i_end_check && rsp_queue.size() != 0) begin
                $error("%0d expected results never arrived", rsp_queue.size());
                errs++;
                rsp_queue.delete();
            end
            o_errors <= o_errors + errs;
        end
    end

endmodule

// ----- dv/tb_bitmap_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator
// Drives page allocator requests in bursts, stalls the result side and walks
// low_reserved_pages through several settings; the checker does the rest.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    localparam int STALL_LIMIT = 200000;   // clearing pass plus a full-map scan

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // [15:0] first_page, [32:16] page_count
    logic [1:0]  s_axis_tuser;     // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;     // [15:0] alloc_page, [32:16] free_pages, [49:33] total
    logic [0:0]  m_axis_tuser;     // [0] ok
    logic        end_check;
    int          err_cnt;
    int          pending_cnt;
    int          idle_cycles;
    int          stall_mode;

    bitmap_page_allocator dut (.*);

    bpa_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .i_rsp_user  (m_axis_tuser),
        .i_end_check (end_check),
        .o_errors    (err_cnt),
        .o_pending   (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: stall pattern switches between always-ready, random and bursty.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 2));
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 15) < 4);
        endcase
    end

    // Watchdog: count cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Hold one request until accepted.
    task automatic send_req(t_mode op, logic [15:0] first, logic [16:0] cnt);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, cnt, first};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge i_clk);
    endtask

    // Write low_reserved_pages once the block has drained.
    task automatic write_low_res(logic [16:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random request, biased to small ranges inside a working window.
    task automatic random_req();
        t_mode       op;
        logic [15:0] first;
        logic [16:0] cnt;
        op = t_mode'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0) begin
            first = 16'($urandom);
            cnt   = 17'($urandom);
        end else begin
            first = 16'($urandom_range(0, 2047));
            cnt   = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 300))
                                                 : 17'($urandom_range(0, 24));
        end
        send_req(op, first, cnt);
    endtask

    initial begin
        int burst_len;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_ALLOC;
        m_axis_tready <= 1'b1;
        stall_mode    <= 0;
        end_check     <= 1'b0;
        idle_cycles   <= 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: allocate before anything is usable, then the extremes.
        send_req(MODE_ALLOC, 16'd0, 17'd1);
        send_req(MODE_ALLOC, 16'd0, 17'd0);
        send_req(MODE_ADD, 16'd0, 17'd1024);
        send_req(MODE_ALLOC, 16'd0, 17'd1);
        send_req(MODE_ALLOC, 16'd0, 17'd100);
        send_req(MODE_RESERVE, 16'd250, 17'd20);
        send_req(MODE_ALLOC, 16'd0, 17'd2000);
        send_req(MODE_FREE, 16'd256, 17'd1);
        send_req(MODE_FREE, 16'd0, 17'd65536);
        send_req(MODE_ADD, 16'hFFFF, 17'd65536);
        send_req(MODE_ADD, 16'd700, 17'd0);
        send_req(MODE_RESERVE, 16'hFFF0, 17'h1FFFF);
        send_req(MODE_ADD, 16'd0, 17'h1FFFF);
        send_req(MODE_ADD, 16'd0, 17'd65536);
        send_req(MODE_ALLOC, 16'd0, 17'h1FFFF);
        send_req(MODE_RESERVE, 16'd0, 17'd65536);
        send_req(MODE_FREE, 16'd0, 17'd512);
        write_low_res(17'd0);
        send_req(MODE_ALLOC, 16'd0, 17'd64);
        send_req(MODE_ALLOC, 16'd0, 17'd3);
        write_low_res(17'd65536);
        send_req(MODE_ALLOC, 16'd0, 17'd1);
        write_low_res(17'h1FFFF);
        send_req(MODE_ALLOC, 16'd0, 17'd1);
        write_low_res(17'd300);
        send_req(MODE_FREE, 16'd0, 17'd65536);

        // Random phases under several low_reserved_pages settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       write_low_res(17'd0);
                1:       write_low_res(LOW_RES_RESET);
                2:       write_low_res(17'd1500);
                3:       write_low_res(17'd65535);
                default: write_low_res(17'($urandom_range(0, 1024)));
            endcase
            for (int n = 0; n < 200; n += burst_len) begin
                burst_len = $urandom_range(1, 20);
                for (int k = 0; k < burst_len; k++) random_req();
                if ($urandom_range(0, 2) != 0) idle_gap();
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        end_check <= 1'b1;
        @(posedge i_clk);
        end_check <= 1'b0;
        repeat (2) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
